[hdl/nsed_pkg.sv]
// ----------------------------------------------------------------------------
// nsed_pkg
// Shared constants, codes and controller/datapath interface types for the
// nearest-string edit distance block.
// ----------------------------------------------------------------------------
package nsed_pkg;

	localparam int MAX_LEN_DEF        = 64;
	localparam int MAX_CANDIDATES_DEF = 256;

	localparam int CHAR_W    = 16;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	localparam logic ACT_QUERY     = 1'b0;
	localparam logic ACT_CANDIDATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic take;
		logic walk;
		logic col_done;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic walk_needed;
		logic walk_done;
		logic end_of_cand;
		logic out_free;
	} sts_t;

endpackage

[hdl/nsed_ctrl.sv]
// ----------------------------------------------------------------------------
// nsed_ctrl
// Sequencer: takes a request, walks one DP column per candidate character,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module nsed_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            action,
	input  logic            last,
	input  nsed_pkg::sts_t  sts,
	output nsed_pkg::cmd_t  cmd
);

	nsed_pkg::state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			nsed_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (action == nsed_pkg::ACT_CANDIDATE) begin
						if (sts.walk_needed)
							state_d = nsed_pkg::ST_WALK;
						else if (last)
							state_d = nsed_pkg::ST_EMIT;
					end
				end
			end
			nsed_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					cmd.col_done = 1'b1;
					state_d = sts.end_of_cand ? nsed_pkg::ST_EMIT : nsed_pkg::ST_IDLE;
				end
			end
			nsed_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = nsed_pkg::ST_IDLE;
				end
			end
			default: state_d = nsed_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= nsed_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[hdl/nsed_dp.sv]
// ----------------------------------------------------------------------------
// nsed_dp
// Datapath: query store, single cost column memory, column update unit,
// best tracking and the output register.
// ----------------------------------------------------------------------------
module nsed_dp #(
	parameter int MAX_LEN        = nsed_pkg::MAX_LEN_DEF,
	parameter int MAX_CANDIDATES = nsed_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nsed_pkg::cmd_t                   cmd,
	output nsed_pkg::sts_t                   sts,
	input  logic                             action,
	input  logic [nsed_pkg::CHAR_W-1:0]      character,
	input  logic                             has_character,
	input  logic                             last,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [nsed_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W  = $clog2(MAX_CANDIDATES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_CANDIDATES - 1);

	logic [nsed_pkg::CHAR_W-1:0] qmem [MAX_LEN];
	logic [LEN_W-1:0]            cmem [MAX_LEN];

	logic                  qopen_q, in_cand_q, ovf_q, cand_ovf_q, end_q;
	logic [LEN_W-1:0]      qlen_q, cand_len_q, idx_q;
	logic [CNT_W-1:0]      cnt_q, best_idx_q;
	logic [LEN_W-1:0]      best_dist_q;
	logic                  best_valid_q;
	logic                  valid_s1;
	logic [LEN_W-1:0]      idx_s1;
	logic [nsed_pkg::CHAR_W-1:0] q_rd_s1;
	logic [LEN_W-1:0]      c_rd_s1;
	logic [nsed_pkg::CHAR_W-1:0] ch_q;
	logic [LEN_W-1:0]      prev_q, left_q;
	logic                  m_tvalid_q;
	logic [nsed_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [LEN_W-1:0] eff_qlen, eff_len, upper, low, col_new, cand_dist, nxt_best_dist;
	logic [CNT_W-1:0] nxt_best_idx;
	logic             rd_en, fresh, take_best, q_take, c_take;

	always_comb begin
		q_take   = cmd.take && (action == nsed_pkg::ACT_QUERY);
		c_take   = cmd.take && (action == nsed_pkg::ACT_CANDIDATE);
		eff_qlen = qopen_q ? qlen_q : '0;
		eff_len  = in_cand_q ? cand_len_q : '0;
		rd_en    = cmd.walk && (idx_q != qlen_q);
		fresh    = (cand_len_q == '0);

		upper = fresh ? (idx_s1 + LEN_W'(1)) : c_rd_s1;
		low   = (left_q < upper) ? left_q : upper;
		low   = (prev_q < low) ? prev_q : low;
		col_new = (q_rd_s1 == ch_q) ? prev_q : (low + LEN_W'(1));

		cand_dist     = fresh ? qlen_q : left_q;
		take_best     = !best_valid_q || (cand_dist < best_dist_q);
		nxt_best_dist = take_best ? cand_dist : best_dist_q;
		nxt_best_idx  = take_best ? cnt_q : best_idx_q;

		sts.walk_needed = has_character && (eff_len != LEN_MAX);
		sts.walk_done   = (idx_q == qlen_q) && !valid_s1;
		sts.end_of_cand = end_q;
		sts.out_free    = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qopen_q      <= 1'b0;
			in_cand_q    <= 1'b0;
			ovf_q        <= 1'b0;
			cand_ovf_q   <= 1'b0;
			end_q        <= 1'b0;
			qlen_q       <= '0;
			cand_len_q   <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			best_idx_q   <= '0;
			best_dist_q  <= '1;
			best_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (q_take) begin
				qopen_q <= !last;
				if (!qopen_q) begin
					ovf_q        <= 1'b0;
					cnt_q        <= '0;
					best_valid_q <= 1'b0;
					best_dist_q  <= '1;
					best_idx_q   <= '0;
					in_cand_q    <= 1'b0;
				end
				if (has_character && (eff_qlen != LEN_MAX))
					qlen_q <= eff_qlen + LEN_W'(1);
				else
					qlen_q <= eff_qlen;
				if (has_character && (eff_qlen == LEN_MAX))
					ovf_q <= 1'b1;
			end
			if (c_take) begin
				qopen_q    <= 1'b0;
				in_cand_q  <= 1'b1;
				cand_len_q <= eff_len;
				end_q      <= last;
				cand_ovf_q <= (in_cand_q && cand_ovf_q) ||
				              (has_character && (eff_len == LEN_MAX));
				idx_q      <= '0;
			end
			if (rd_en)
				idx_q <= idx_q + LEN_W'(1);
			if (cmd.col_done)
				cand_len_q <= cand_len_q + LEN_W'(1);
			if (cmd.emit) begin
				best_valid_q <= 1'b1;
				best_dist_q  <= nxt_best_dist;
				best_idx_q   <= nxt_best_idx;
				in_cand_q    <= 1'b0;
				if (cnt_q != CNT_TOP)
					cnt_q <= cnt_q + CNT_W'(1);
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take && has_character && (eff_qlen != LEN_MAX))
			qmem[eff_qlen[ADDR_W-1:0]] <= character;
		if (c_take && sts.walk_needed) begin
			ch_q   <= character;
			prev_q <= eff_len;
			left_q <= eff_len + LEN_W'(1);
		end
		if (rd_en) begin
			q_rd_s1 <= qmem[idx_q[ADDR_W-1:0]];
			c_rd_s1 <= cmem[idx_q[ADDR_W-1:0]];
		end
		idx_s1 <= idx_q;
		if (valid_s1) begin
			cmem[idx_s1[ADDR_W-1:0]] <= col_new;
			left_q <= col_new;
			prev_q <= upper;
		end
		if (cmd.emit)
			m_tdata_q <= {1'b0, ovf_q | cand_ovf_q, 7'(nxt_best_dist), 8'(nxt_best_idx),
			              8'(cnt_q), 7'(cand_dist)};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hdl/nearest_string_by_edit_distance.sv]
// ----------------------------------------------------------------------------
// nearest_string_by_edit_distance
// Finds the candidate string nearest to a loaded query by Levenshtein distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one 16-bit code unit per request. tuser = 0 loads the
//   query, tuser = 1 feeds a candidate; tlast closes the string; has_character
//   = 0 lets an empty string be sent. The first query request after a closed
//   query starts a new query and clears the best.
//   Output stream (m_*): one result per candidate request with tlast set:
//   its distance and index, the best distance and index so far, and overflow.
//   Timing: a candidate character is scored by a column walk that reads one
//   query/cost memory entry per cycle, at most MAX_LEN entries, through a
//   one-stage update unit; query requests and empty or dropped candidate
//   requests need no walk. Ending a candidate loads the output register once
//   the output is free.
//   A held result does not block input; only a second result waits for the
//   receiver to take the first. Reset empties the query and the best; the
//   memories need no clearing pass.
// ----------------------------------------------------------------------------
module nearest_string_by_edit_distance #(
	parameter int MAX_LEN        = nsed_pkg::MAX_LEN_DEF,
	parameter int MAX_CANDIDATES = nsed_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [nsed_pkg::S_TDATA_W-1:0]  s_tdata,  // character[15:0], has_character[16]
	input  logic [0:0]                      s_tuser,  // action[0]
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// distance[6:0], candidate_index[14:7], best_index[22:15],
	// best_distance[29:23], overflow[30]
	output logic [nsed_pkg::M_TDATA_W-1:0]  m_tdata
);

	nsed_pkg::cmd_t cmd;
	nsed_pkg::sts_t sts;

	nsed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser[0]),
		.last     (s_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	nsed_dp #(
		.MAX_LEN        (MAX_LEN),
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (s_tuser[0]),
		.character     (s_tdata[nsed_pkg::CHAR_W-1:0]),
		.has_character (s_tdata[nsed_pkg::CHAR_W]),
		.last          (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

	ap_best_not_above: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[29:23] <= m_tdata[6:0]))
		else $error("best distance above reported distance");

	ap_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.emit))
		else $error("result raised without emit");

	ap_walk_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && s_tuser[0] && sts.walk_needed) |=> cmd.walk)
		else $error("column walk did not start");

	ap_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwritten before taken");

endmodule

[test/tb_nearest_string_by_edit_distance.sv]
// ----------------------------------------------------------------------------
// tb_nearest_string_by_edit_distance
// Self-checking bench for the nearest-string edit distance block. A cycle-free
// Levenshtein scorer tracks the query, the cost column and the running best;
// every accepted request updates it and each candidate end queues the match
// the block has to report. Directed strings, overflow, index saturation and
// random string traffic run with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_nearest_string_by_edit_distance;

	localparam int QMAX       = nsed_pkg::MAX_LEN_DEF;
	localparam int CAND_LIMIT = nsed_pkg::MAX_CANDIDATES_DEF;
	localparam int SETTLE     = QMAX + 8;

	typedef struct packed {
		logic [6:0] distance;
		logic [7:0] cand_index;
		logic [7:0] best_index;
		logic [6:0] best_distance;
		logic       overflow;
	} match_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [nsed_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
	logic [0:0]                      s_tuser  = '0;
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [nsed_pkg::M_TDATA_W-1:0]  m_tdata;

	nearest_string_by_edit_distance dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	// scorer state
	logic [15:0] q_chars [QMAX];
	int          col [QMAX+1];
	int          q_len, c_len, c_count, best_dist, best_idx;
	logic        q_ovf, c_ovf, in_cand, q_open, best_seen;

	match_t      pending_matches [$];
	int          mismatches   = 0;
	bit          calm         = 0;
	int          tx_gap_pct   = 0;
	int          rx_stall_pct = 0;
	logic [15:0] alpha [4];

	task automatic score_request(input logic act, input logic [15:0] ch,
			input logic has_ch, input logic lst);
		int     prev, upper, m, cand_dist;
		match_t r;
		if (act == nsed_pkg::ACT_QUERY) begin
			if (!q_open) begin
				q_open    = 1;
				q_len     = 0;
				q_ovf     = 0;
				c_count   = 0;
				best_dist = 127;
				best_idx  = 0;
				best_seen = 0;
				in_cand   = 0;
			end
			if (has_ch) begin
				if (q_len < QMAX) begin
					q_chars[q_len] = ch;
					q_len++;
				end else begin
					q_ovf = 1;
				end
			end
			if (lst)
				q_open = 0;
		end else begin
			q_open = 0;
			if (!in_cand) begin
				in_cand = 1;
				c_len   = 0;
				c_ovf   = 0;
				for (int i = 0; i <= q_len; i++)
					col[i] = i;
			end
			if (has_ch) begin
				if (c_len < QMAX) begin
					prev   = col[0];
					col[0] = c_len + 1;
					for (int i = 0; i < q_len; i++) begin
						upper = col[i+1];
						if (q_chars[i] == ch) begin
							col[i+1] = prev;
						end else begin
							m = (col[i] < upper) ? col[i] : upper;
							m = (m < prev) ? m : prev;
							col[i+1] = m + 1;
						end
						prev = upper;
					end
					c_len++;
				end else begin
					c_ovf = 1;
				end
			end
			if (lst) begin
				cand_dist = col[q_len];
				if (!best_seen || cand_dist < best_dist) begin
					best_seen = 1;
					best_dist = cand_dist;
					best_idx  = c_count;
				end
				r.distance      = cand_dist[6:0];
				r.cand_index    = c_count[7:0];
				r.best_index    = best_idx[7:0];
				r.best_distance = best_dist[6:0];
				r.overflow      = q_ovf | c_ovf;
				pending_matches = {pending_matches, r};
				if (c_count < CAND_LIMIT - 1)
					c_count++;
				in_cand = 0;
			end
		end
	endtask

	task automatic send_item(input logic act, input logic [15:0] ch,
			input logic has_ch, input logic lst);
		if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, has_ch, ch};
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		score_request(act, ch, has_ch, lst);
	endtask

	task automatic send_text(input logic act, input string s);
		if (s.len() == 0) begin
			send_item(act, 16'h0000, 1'b0, 1'b1);
		end else begin
			for (int i = 0; i < s.len(); i++)
				send_item(act, {8'd0, s[i]}, 1'b1, i == s.len() - 1);
		end
	endtask

	function automatic logic [15:0] pick_char();
		if ($urandom_range(0, 3) != 0)
			return alpha[$urandom_range(0, 3)];
		return 16'($urandom);
	endfunction

	task automatic send_word(input logic act, input int len);
		if (len == 0) begin
			send_item(act, 16'($urandom), 1'b0, 1'b1);
		end else begin
			for (int i = 0; i < len; i++)
				send_item(act, pick_char(), 1'b1, i == len - 1);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int pick_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// mostly well-formed query/candidate runs, the rest random requests
	task automatic run_traffic(input int budget);
		int sent, len, n;
		sent = 0;
		while (sent < budget) begin
			tx_gap_pct   = pick_pct();
			rx_stall_pct = pick_pct();
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 2) == 0) begin
					for (int k = 0; k < 4; k++)
						alpha[k] = ($urandom_range(0, 7) == 0) ? {16{k[0]}} : 16'($urandom);
					len = pick_len();
					send_word(nsed_pkg::ACT_QUERY, len);
					sent += (len == 0) ? 1 : len;
				end
				n = $urandom_range(1, 4);
				repeat (n) begin
					len = pick_len();
					if ($urandom_range(0, 4) == 0) begin
						send_item(nsed_pkg::ACT_CANDIDATE, 16'($urandom), 1'b0, 1'b0);
						sent++;
					end
					send_word(nsed_pkg::ACT_CANDIDATE, len);
					sent += (len == 0) ? 1 : len;
				end
			end else begin
				send_item(1'($urandom_range(0, 1)), 16'($urandom),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		tx_gap_pct   = 30;
		rx_stall_pct = 30;
		// candidates before any query see an empty query
		send_text(nsed_pkg::ACT_CANDIDATE, "");
		send_text(nsed_pkg::ACT_CANDIDATE, "ab");
		// first minimum wins on ties
		send_text(nsed_pkg::ACT_QUERY, "cat");
		send_text(nsed_pkg::ACT_CANDIDATE, "cut");
		send_text(nsed_pkg::ACT_CANDIDATE, "bat");
		send_text(nsed_pkg::ACT_CANDIDATE, "cat");
		send_text(nsed_pkg::ACT_CANDIDATE, "cat");
		send_text(nsed_pkg::ACT_CANDIDATE, "");
		// extreme code units
		send_item(nsed_pkg::ACT_QUERY, 16'hFFFF, 1'b1, 1'b0);
		send_item(nsed_pkg::ACT_QUERY, 16'h0000, 1'b1, 1'b1);
		send_item(nsed_pkg::ACT_CANDIDATE, 16'h0000, 1'b1, 1'b0);
		send_item(nsed_pkg::ACT_CANDIDATE, 16'hFFFF, 1'b1, 1'b1);
		// candidate closes an open query
		send_item(nsed_pkg::ACT_QUERY, 16'h0078, 1'b1, 1'b0);
		send_item(nsed_pkg::ACT_CANDIDATE, 16'h0078, 1'b1, 1'b1);
		// a new query abandons an unfinished candidate
		send_item(nsed_pkg::ACT_CANDIDATE, 16'h0061, 1'b1, 1'b0);
		send_item(nsed_pkg::ACT_QUERY, 16'h0071, 1'b1, 1'b1);
		send_item(nsed_pkg::ACT_CANDIDATE, 16'h0071, 1'b1, 1'b1);
		// empty query, empty item inside a candidate
		send_text(nsed_pkg::ACT_QUERY, "");
		send_item(nsed_pkg::ACT_CANDIDATE, 16'h0041, 1'b1, 1'b0);
		send_item(nsed_pkg::ACT_CANDIDATE, 16'h5A5A, 1'b0, 1'b0);
		send_item(nsed_pkg::ACT_CANDIDATE, 16'h0042, 1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_overflow();
		tx_gap_pct   = 10;
		rx_stall_pct = 20;
		for (int k = 0; k < 4; k++)
			alpha[k] = 16'($urandom);
		// query overflow is sticky for the following candidate
		send_word(nsed_pkg::ACT_QUERY, QMAX + 1);
		send_word(nsed_pkg::ACT_CANDIDATE, 2);
		// short query, candidate one over the limit
		send_word(nsed_pkg::ACT_QUERY, 2);
		send_word(nsed_pkg::ACT_CANDIDATE, QMAX + 1);
		wait_idle();
	endtask

	task automatic test_index_saturation();
		tx_gap_pct   = 10;
		rx_stall_pct = 10;
		send_text(nsed_pkg::ACT_QUERY, "ab");
		repeat (CAND_LIMIT + 2) begin
			if ($urandom_range(0, 3) == 0)
				send_item(nsed_pkg::ACT_CANDIDATE, 16'h0000, 1'b0, 1'b1);
			else
				send_item(nsed_pkg::ACT_CANDIDATE, 16'h0061 + 16'($urandom_range(0, 2)),
					1'b1, 1'b1);
		end
		wait_idle();
	endtask

	task automatic test_random();
		run_traffic(30);
		wait_idle();
	endtask

	task automatic test_back_to_back();
		calm = 1;
		run_traffic(15);
	endtask

	always @(posedge clk) begin
		int hold;
		if (hold != 0)
			hold--;
		else if (!calm && $urandom_range(0, 99) < rx_stall_pct)
			hold = $urandom_range(1, 12);
		m_tready <= (hold == 0);
	end

	always @(posedge clk) begin
		match_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[6:0], m_tdata[14:7], m_tdata[22:15], m_tdata[29:23],
				m_tdata[30]};
			if (pending_matches.size() == 0) begin
				$error("unexpected result: tdata %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_matches.pop_front();
				if (got.distance != want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, got.distance);
					mismatches++;
				end
				if (got.cand_index != want.cand_index) begin
					$error("candidate_index: expected %0d, got %0d", want.cand_index,
						got.cand_index);
					mismatches++;
				end
				if (got.best_index != want.best_index) begin
					$error("best_index: expected %0d, got %0d", want.best_index,
						got.best_index);
					mismatches++;
				end
				if (got.best_distance != want.best_distance) begin
					$error("best_distance: expected %0d, got %0d", want.best_distance,
						got.best_distance);
					mismatches++;
				end
				if (got.overflow != want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		q_len     = 0;
		c_len     = 0;
		c_count   = 0;
		best_dist = 127;
		best_idx  = 0;
		q_ovf     = 0;
		c_ovf     = 0;
		in_cand   = 0;
		q_open    = 0;
		best_seen = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_index_saturation();
		test_random();
		test_back_to_back();
		wait_idle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
